@@ src/sof_pkg.sv @@
// ----------------------------------------------------------------------------
// sof_pkg
// shared types and constants of the substring occurrence finder
// ----------------------------------------------------------------------------
package sof_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 32;
  localparam logic [POS_W-1:0] POS_MAX = 32'hFFFF_FFFF;

  // command codes carried in tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_SUBJECT = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // register indexes, decoded from paddr[2]
  localparam logic REG_START = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // per-word control broadcast to the cell row
  typedef struct packed {
    logic shift;   // subject byte enters the window
    logic append;  // pattern byte enters the pattern row
    logic clear;   // empty pattern, zero window
  } row_ctl_t;

endpackage

@@ src/substring_occurrence_finder_core.sv @@
// ----------------------------------------------------------------------------
// substring_occurrence_finder_core
// finds every (overlapping) occurrence of a stored pattern in a byte stream
//
// channel | dir | handshake           | word
// in_     | in  | in_tvalid/in_tready | tdata: data_byte, tuser: cmd
// out_    | out | out_tvalid/out_tready | tdata: match_position
// cfg_    | in  | apb, pready tied high | start_position @0x0, limit @0x4
//
// - one word accepted per cycle while in_tready is high, any mix of append, subject and clear
// - a match shows on out_ after its subject word has passed these registers:
//   the cell row and count update at the edge that takes the word, the row
//   compare and position subtract are registered in stage 2, then the range
//   check fills the output register
// - a stalled output fills the pipeline before in_tready drops
// - reset is synchronous active low: empty pattern, zero window and count,
//   start_position 1, limit all ones; no clearing pass
// ----------------------------------------------------------------------------
module substring_occurrence_finder_core #(
  parameter int unsigned PAT_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] match_position
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned LEN_W = $clog2(PAT_MAX + 1);
  localparam int unsigned POS_W = sof_pkg::POS_W;

  // configuration registers
  logic [POS_W-1:0] start_r;
  logic [POS_W-1:0] limit_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= POS_W'(1);
      limit_r <= sof_pkg::POS_MAX;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        sof_pkg::REG_START: start_r <= cfg_pwdata;
        sof_pkg::REG_LIMIT: limit_r <= cfg_pwdata;
        default:            start_r <= start_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      sof_pkg::REG_START: cfg_prdata = start_r;
      sof_pkg::REG_LIMIT: cfg_prdata = limit_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // pipeline handshake: each stage moves when the one after it has room
  logic out_v_r;
  logic s1_v_r;
  logic s2_v_r;
  logic out_room;
  logic s2_adv;
  logic s1_adv;
  logic in_fire;

  assign out_room  = !out_v_r || out_tready;
  assign s2_adv    = !s2_v_r || out_room;
  assign s1_adv    = !s1_v_r || s2_adv;
  assign in_tready = s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // command decode
  sof_pkg::cmd_t     cmd;
  sof_pkg::row_ctl_t ctl;

  assign cmd = sof_pkg::cmd_t'(in_tuser);

  always_comb begin
    ctl = '0;
    if (in_fire) begin
      unique case (cmd)
        sof_pkg::CMD_APPEND:  ctl.append = 1'b1;
        sof_pkg::CMD_SUBJECT: ctl.shift  = 1'b1;
        sof_pkg::CMD_CLEAR:   ctl.clear  = 1'b1;
        default:              ctl        = '0;  // unused code, no effect
      endcase
    end
  end

  // saturating subject counter
  logic [POS_W-1:0] count_r;
  logic [POS_W-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.shift && (count_r != sof_pkg::POS_MAX)) begin
      count_nxt = count_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // cell row: window shifts on subject words, pattern on append words
  logic [LEN_W-1:0] pat_len;
  logic             match_all;

  sof_row #(
    .PAT_MAX (PAT_MAX),
    .LEN_W   (LEN_W)
  ) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (in_tdata),
    .pat_len   (pat_len),
    .match_all (match_all)
  );

  // stage 1: row state belongs to the subject word held here, since no new
  // word is taken while this stage is stuck
  logic             hit;
  logic [POS_W-1:0] len_ext;
  logic [POS_W-1:0] s1_pos;
  logic [POS_W-1:0] s2_pos_r;

  assign len_ext = POS_W'(pat_len);
  assign hit     = match_all && (count_r >= len_ext);
  // empty pattern matches at the current position
  assign s1_pos  = (pat_len == '0) ? count_r : (count_r - len_ext + POS_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= ctl.shift;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r && hit;
      end
      if (out_room) begin
        out_v_r <= s2_v_r && (s2_pos_r >= start_r) && (s2_pos_r <= limit_r);
      end
    end
  end

  // stage 2 position and output register, payload only
  logic [POS_W-1:0] out_pos_r;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_pos_r <= s1_pos;
    end
    if (out_room) begin
      out_pos_r <= s2_pos_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pos_r;

`ifndef SYNTHESIS
  // a reported position is never zero
  a_pos_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata != '0))
    else $error("zero match position reported");

  // clear empties pattern and count
  a_clear : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (count_r == '0) && (pat_len == '0))
    else $error("clear did not restart");

  // counter sticks at its maximum
  a_sat : assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.shift && (count_r == sof_pkg::POS_MAX)) |=> (count_r == sof_pkg::POS_MAX))
    else $error("subject counter wrapped");

  // a held subject word keeps its slot while the pipeline is blocked
  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> s1_v_r)
    else $error("stage 1 lost its word");
`endif

endmodule

@@ src/sof_cell.sv @@
// ----------------------------------------------------------------------------
// sof_cell
// one window byte and one pattern byte, both handed on to the next cell
// ----------------------------------------------------------------------------
module sof_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned LEN_W = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sof_pkg::row_ctl_t          ctl,
  input  logic [LEN_W-1:0]           pat_len,
  input  logic [sof_pkg::BYTE_W-1:0] win_in,
  input  logic [sof_pkg::BYTE_W-1:0] pat_in,
  output logic [sof_pkg::BYTE_W-1:0] win_out,
  output logic [sof_pkg::BYTE_W-1:0] pat_out,
  output logic                       eq
);

  logic [sof_pkg::BYTE_W-1:0] win_r;
  logic [sof_pkg::BYTE_W-1:0] pat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.clear) begin
      win_r <= '0;
    end else if (ctl.shift) begin
      win_r <= win_in;
    end
  end

  // pattern byte needs no reset, unused cells are masked by the length
  always_ff @(posedge clk) begin
    if (ctl.append) begin
      pat_r <= pat_in;
    end
  end

  assign win_out = win_r;
  assign pat_out = pat_r;
  // cell holds pattern[len-1-IDX] against window[IDX]
  assign eq = (LEN_W'(IDX) >= pat_len) || (pat_r == win_r);

endmodule

@@ src/sof_row.sv @@
// ----------------------------------------------------------------------------
// sof_row
// row of compare cells plus the pattern length register
// ----------------------------------------------------------------------------
module sof_row #(
  parameter int unsigned PAT_MAX = 32,
  parameter int unsigned LEN_W   = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sof_pkg::row_ctl_t          ctl,
  input  logic [sof_pkg::BYTE_W-1:0] data_byte,
  output logic [LEN_W-1:0]           pat_len,
  output logic                       match_all
);

  logic [LEN_W-1:0]           len_r;
  logic [LEN_W-1:0]           len_nxt;
  logic                       full;
  sof_pkg::row_ctl_t          cell_ctl;
  logic [sof_pkg::BYTE_W-1:0] win_link [PAT_MAX+1];
  logic [sof_pkg::BYTE_W-1:0] pat_link [PAT_MAX+1];
  logic [PAT_MAX-1:0]         eq_vec;

  assign full = (len_r == LEN_W'(PAT_MAX));

  // append to a full pattern is dropped
  always_comb begin
    cell_ctl        = ctl;
    cell_ctl.append = ctl.append && !full;
  end

  always_comb begin
    len_nxt = len_r;
    if (ctl.clear) begin
      len_nxt = '0;
    end else if (cell_ctl.append) begin
      len_nxt = len_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign win_link[0] = data_byte;
  assign pat_link[0] = data_byte;

  for (genvar g = 0; g < PAT_MAX; g++) begin : g_cell
    sof_cell #(
      .IDX   (g),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .pat_len (len_r),
      .win_in  (win_link[g]),
      .pat_in  (pat_link[g]),
      .win_out (win_link[g+1]),
      .pat_out (pat_link[g+1]),
      .eq      (eq_vec[g])
    );
  end

  assign pat_len   = len_r;
  assign match_all = &eq_vec;

endmodule
